// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, checked while out of reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== rtl/sha1md_pkg.sv =====
// Package: shared types, codes and round functions of the SHA-1 engine.
package sha1md_pkg;

    localparam logic [1:0] KIND_BYTE   = 2'd0;
    localparam logic [1:0] KIND_FINISH = 2'd1;
    localparam logic [1:0] KIND_START  = 2'd2;

    localparam logic [2:0] OP_NOP   = 3'd0;
    localparam logic [2:0] OP_LOAD  = 3'd1;
    localparam logic [2:0] OP_PADB  = 3'd2;
    localparam logic [2:0] OP_ROUND = 3'd3;
    localparam logic [2:0] OP_ADD   = 3'd4;
    localparam logic [2:0] OP_EMIT  = 3'd5;

    localparam logic [159:0] H_INIT = {32'h67452301, 32'hefcdab89, 32'h98badcfe,
                                       32'h10325476, 32'hc3d2e1f0};

    typedef struct packed {
        logic [2:0] op;
        logic [6:0] rnd;
        logic [7:0] pad;
    } t_core_ctl;

    function automatic logic [31:0] sha1md_k(input logic [6:0] rnd);
        logic [31:0] k;
        if (rnd < 7'd20)      k = 32'h5a827999;
        else if (rnd < 7'd40) k = 32'h6ed9eba1;
        else if (rnd < 7'd60) k = 32'h8f1bbcdc;
        else                  k = 32'hca62c1d6;
        return k;
    endfunction

    function automatic logic [31:0] sha1md_f(input logic [6:0] rnd, input logic [31:0] b,
                                             input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        if (rnd < 7'd20)      f = d ^ (b & (c ^ d));
        else if (rnd < 7'd40) f = b ^ c ^ d;
        else if (rnd < 7'd60) f = (b & c) | (b & d) | (c & d);
        else                  f = b ^ c ^ d;
        return f;
    endfunction

endpackage

// ===== rtl/sha1md_core.sv =====
// Compression datapath: schedule window, working words and hash words.
module sha1md_core (
    input  logic                  i_clk,
    input  sha1md_pkg::t_core_ctl i_ctl,
    input  logic [511:0]          i_blk,
    input  logic [159:0]          i_chain,
    output logic [31:0]           o_word,
    output logic [159:0]          o_hash
);
    import sha1md_pkg::*;

    logic [511:0] r_w;
    logic [31:0]  r_a, r_b, r_c, r_d, r_e;
    logic [31:0]  r_hw [5];
    logic [31:0]  wt, w_new, tmp, sum;

    assign wt    = r_w[511:480];
    assign w_new = {r_w[95:64] ^ r_w[255:224] ^ r_w[447:416] ^ r_w[511:480]};
    assign tmp   = {r_a[26:0], r_a[31:27]} + sha1md_f(i_ctl.rnd, r_b, r_c, r_d)
                   + r_e + wt + sha1md_k(i_ctl.rnd);
    assign sum   = r_hw[0] + r_a;

    always_ff @(posedge i_clk) begin
        case (i_ctl.op)
            OP_LOAD: begin
                r_w <= i_blk;
                r_a <= i_chain[159:128];
                r_b <= i_chain[127:96];
                r_c <= i_chain[95:64];
                r_d <= i_chain[63:32];
                r_e <= i_chain[31:0];
                for (int i = 0; i < 5; i++) begin
                    r_hw[i] <= i_chain[159 - 32 * i -: 32];
                end
            end
            OP_PADB: begin
                r_w <= {r_w[503:0], i_ctl.pad};
            end
            OP_ROUND: begin
                r_w <= {r_w[479:0], w_new[30:0], w_new[31]};
                r_e <= r_d;
                r_d <= r_c;
                r_c <= {r_b[1:0], r_b[31:2]};
                r_b <= r_a;
                r_a <= tmp;
            end
            OP_ADD: begin
                // hash words and working words rotate together; both end as the sums
                for (int i = 0; i < 4; i++) begin
                    r_hw[i] <= r_hw[i + 1];
                end
                r_hw[4] <= sum;
                r_a <= r_b;
                r_b <= r_c;
                r_c <= r_d;
                r_d <= r_e;
                r_e <= sum;
            end
            OP_EMIT: begin
                for (int i = 0; i < 4; i++) begin
                    r_hw[i] <= r_hw[i + 1];
                end
                r_hw[4] <= r_hw[0];
            end
            default: begin
            end
        endcase
    end

    assign o_word = r_hw[0];
    assign o_hash = {r_hw[0], r_hw[1], r_hw[2], r_hw[3], r_hw[4]};

endmodule

// ===== rtl/sha1_message_digest_top.sv =====
// Top level: SHA-1 engine taking one message byte per word, emitting five digest words.
//
// Message bytes are taken one per cycle while idle until a 64-byte block is complete;
// the word that completes a block starts its compression, which occupies the single
// round unit for all 80 rounds, then five chaining additions through one adder and a
// store of the chain, after which the next word is taken. A finish word pads into the
// schedule window at one byte per cycle (64 minus the pending byte count), compresses,
// and when 56 or more bytes were pending pads and compresses a second block; the five
// digest words then leave one per cycle through the output register as the sink accepts
// them, and the next word is taken once the last is in the output register. Start and
// unused kinds are taken without leaving idle.
// The chaining words, byte count and length are kept, so a message may continue after a
// finish. There is no clearing pass after reset.
module sha1_message_digest_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic [1:0]  s_axis_tuser,   // [1:0] kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] digest_word
    output logic [2:0]  m_axis_tuser,   // [2:0] word_index
    output logic        m_axis_tlast
);
    import sha1md_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PAD   = 3'd1;
    localparam logic [2:0] S_ROUND = 3'd2;
    localparam logic [2:0] S_ADD   = 3'd3;
    localparam logic [2:0] S_SAVE  = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0]   r_state;
    logic [6:0]   r_cnt;
    logic [5:0]   r_fill;
    logic [60:0]  r_msg;
    logic [159:0] r_chain;
    logic [511:0] r_buf;
    logic [63:0]  r_len;
    logic [6:0]   r_pos;
    logic         r_fin, r_two, r_second;
    logic         r_ovalid;
    logic [31:0]  r_odata;
    logic [2:0]   r_oidx;

    t_core_ctl    ctl;
    logic [511:0] blk;
    logic [31:0]  core_word;
    logic [159:0] core_hash;
    logic         acc, out_free, last_blk, len_zone;
    logic [7:0]   pad_byte;
    logic [60:0]  len_bytes;

    assign acc       = s_axis_tvalid && s_axis_tready;
    assign out_free  = !r_ovalid || m_axis_tready;
    assign last_blk  = r_two ? r_pos[6] : 1'b1;
    assign len_zone  = last_blk && (r_pos[5:3] == 3'b111);
    assign pad_byte  = (r_pos == {1'b0, r_fill}) ? 8'h80 :
                       len_zone ? r_len[63:56] : 8'h00;
    assign len_bytes = r_msg + {55'd0, r_fill};
    assign blk       = (s_axis_tuser == KIND_BYTE) ? {r_buf[503:0], s_axis_tdata} : r_buf;

    always_comb begin
        ctl.op  = OP_NOP;
        ctl.rnd = r_cnt;
        ctl.pad = pad_byte;
        case (r_state)
            S_IDLE: begin
                if (acc && s_axis_tuser == KIND_BYTE && r_fill == 6'd63) begin
                    ctl.op = OP_LOAD;
                end else if (acc && s_axis_tuser == KIND_FINISH) begin
                    ctl.op = OP_LOAD;
                end
            end
            S_PAD:   ctl.op = OP_PADB;
            S_ROUND: ctl.op = OP_ROUND;
            S_ADD:   ctl.op = OP_ADD;
            S_OUT: begin
                if (out_free) begin
                    ctl.op = OP_EMIT;
                end
            end
            default: ctl.op = OP_NOP;
        endcase
    end

    sha1md_core u_core (
        .i_clk   (i_clk),
        .i_ctl   (ctl),
        .i_blk   (blk),
        .i_chain (r_chain),
        .o_word  (core_word),
        .o_hash  (core_hash)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_fill   <= '0;
            r_msg    <= '0;
            r_chain  <= H_INIT;
            r_len    <= '0;
            r_pos    <= '0;
            r_fin    <= 1'b0;
            r_two    <= 1'b0;
            r_second <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && m_axis_tready && r_state != S_OUT) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (acc) begin
                        case (s_axis_tuser)
                            KIND_BYTE: begin
                                r_buf <= {r_buf[503:0], s_axis_tdata};
                                if (r_fill == 6'd63) begin
                                    r_fill  <= '0;
                                    r_msg   <= r_msg + 61'd64;
                                    r_fin   <= 1'b0;
                                    r_cnt   <= '0;
                                    r_state <= S_ROUND;
                                end else begin
                                    r_fill <= r_fill + 6'd1;
                                end
                            end
                            KIND_FINISH: begin
                                r_len    <= {len_bytes, 3'b000};
                                r_pos    <= {1'b0, r_fill};
                                r_two    <= (r_fill[5:3] == 3'b111);
                                r_second <= 1'b0;
                                r_fin    <= 1'b1;
                                r_state  <= S_PAD;
                            end
                            KIND_START: begin
                                r_chain <= H_INIT;
                                r_fill  <= '0;
                                r_msg   <= '0;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_PAD: begin
                    r_pos <= r_pos + 7'd1;
                    if (len_zone) begin
                        r_len <= {r_len[55:0], 8'h00};
                    end
                    if (r_pos[5:0] == 6'd63) begin
                        r_cnt   <= '0;
                        r_state <= S_ROUND;
                    end
                end
                S_ROUND: begin
                    if (r_cnt == 7'd79) begin
                        r_cnt   <= '0;
                        r_state <= S_ADD;
                    end else begin
                        r_cnt <= r_cnt + 7'd1;
                    end
                end
                S_ADD: begin
                    if (r_cnt == 7'd4) begin
                        r_cnt <= '0;
                        if (!r_fin) begin
                            r_state <= S_SAVE;
                        end else if (r_two && !r_second) begin
                            r_second <= 1'b1;
                            r_state  <= S_PAD;
                        end else begin
                            r_state <= S_OUT;
                        end
                    end else begin
                        r_cnt <= r_cnt + 7'd1;
                    end
                end
                S_SAVE: begin
                    r_chain <= core_hash;
                    r_state <= S_IDLE;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_odata  <= core_word;
                        r_oidx   <= r_cnt[2:0];
                        r_ovalid <= 1'b1;
                        if (r_cnt == 7'd4) begin
                            r_cnt   <= '0;
                            r_state <= S_IDLE;
                        end else begin
                            r_cnt <= r_cnt + 7'd1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_oidx;
    assign m_axis_tlast  = (r_oidx == 3'd4);

endmodule

// ===== rtl/sha1md_checker.sv =====
// Port-level checker for the SHA-1 engine, bound to the top level.
`include "assert_macros.svh"

module sha1md_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [1:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser,
    input logic        m_axis_tlast
);
    import sha1md_pkg::*;

    logic        fin_acc;
    logic        out_acc;
    logic        out_stall;
    logic [35:0] out_bus;
    logic        last_ok;
    logic        idx_ok;

    assign fin_acc   = s_axis_tvalid && s_axis_tready && (s_axis_tuser == KIND_FINISH);
    assign out_acc   = m_axis_tvalid && m_axis_tready;
    assign out_stall = m_axis_tvalid && !m_axis_tready;
    assign out_bus   = {m_axis_tlast, m_axis_tuser, m_axis_tdata};
    assign last_ok   = (m_axis_tlast == (m_axis_tuser == 3'd4));
    assign idx_ok    = (m_axis_tuser <= 3'd4);

    `ASSERT_IMPLY(a_last_on_final, i_clk, i_rst_n, m_axis_tvalid, last_ok)
    `ASSERT_NEXT(a_busy_after_finish, i_clk, i_rst_n, fin_acc, !s_axis_tready)
    `ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, out_stall, m_axis_tvalid && $stable(out_bus))
    `ASSERT_IMPLY(a_index_range, i_clk, i_rst_n, out_acc, idx_ok)

endmodule

bind sha1_message_digest_top sha1md_checker u_sha1md_checker (.*);
